### rtl/core/wsp_integer_field_encoder_unit_assert.svh
// assertion macros for the wsp integer field encoder
// used by the port checker, no other dependencies
`ifndef WSP_INTEGER_FIELD_ENCODER_UNIT_ASSERT_SVH
`define WSP_INTEGER_FIELD_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define WSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define WSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/wsp_enc_pkg.sv
// shared types and codes for the wsp integer field encoder
// no dependencies
package wsp_enc_pkg;

  localparam int unsigned MaxBytes = 6;

  localparam logic [3:0] KIND_INT8    = 4'd0;
  localparam logic [3:0] KIND_INT16   = 4'd1;
  localparam logic [3:0] KIND_INT32   = 4'd2;
  localparam logic [3:0] KIND_SHORT   = 4'd3;
  localparam logic [3:0] KIND_LONG    = 4'd4;
  localparam logic [3:0] KIND_INTEGER = 4'd5;
  localparam logic [3:0] KIND_UINTVAR = 4'd6;
  localparam logic [3:0] KIND_VLENGTH = 4'd7;
  localparam logic [3:0] KIND_MINIMAL = 4'd8;

  localparam logic [7:0] SHORT_FLAG   = 8'h80;
  localparam logic [7:0] SHORT_MAX    = 8'h7f;
  localparam logic [7:0] VLEN_MAX     = 8'd30;
  localparam logic [7:0] VLEN_QUOTE   = 8'd31;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_req_t;

  // encoded bytes, entry 0 goes out first
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               count;
  } enc_t;

endpackage

### rtl/core/wsp_enc_stage.sv
// input register stage of the wsp integer field encoder
// depends on wsp_enc_pkg
module wsp_enc_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_ready,
  input  wsp_enc_pkg::in_req_t src_data,
  input  logic                take,
  output logic                held_valid,
  output wsp_enc_pkg::in_req_t held_data
);

  logic held_valid_next;

  assign src_ready       = !held_valid || take;
  assign held_valid_next = (src_valid && src_ready) || (held_valid && !take);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      held_data <= src_data;
    end
  end

endmodule

### rtl/core/wsp_enc_pack.sv
// byte encoder: turns one request into up to six bytes and a count
// depends on wsp_enc_pkg
module wsp_enc_pack (
  input  wsp_enc_pkg::in_req_t req,
  output wsp_enc_pkg::enc_t    enc
);

  logic [31:0]     v;
  logic [3:0][7:0] vb;
  logic [4:0][6:0] grp;
  logic [2:0]      mb;
  logic [2:0]      g;
  logic [3:0][7:0] m;
  logic [4:0][7:0] u;
  logic [1:0]      mi;
  logic [2:0]      gi;

  assign v  = req.value;
  assign vb = v;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      grp[i] = v[7*i +: 7];
    end
    grp[4] = {3'b000, v[31:28]};

    if (v[31:24] != 8'h00) begin
      mb = 3'd4;
    end else if (v[23:16] != 8'h00) begin
      mb = 3'd3;
    end else if (v[15:8] != 8'h00) begin
      mb = 3'd2;
    end else begin
      mb = 3'd1;
    end

    if (v[31:28] != 4'h0) begin
      g = 3'd5;
    end else if (v[27:21] != 7'h00) begin
      g = 3'd4;
    end else if (v[20:14] != 7'h00) begin
      g = 3'd3;
    end else if (v[13:7] != 7'h00) begin
      g = 3'd2;
    end else begin
      g = 3'd1;
    end
  end

  // minimal big-endian bytes, left aligned
  always_comb begin
    m  = '0;
    mi = '0;
    for (int j = 0; j < 4; j++) begin
      mi = 2'(mb - 3'd1 - 3'(j));
      if (3'(j) < mb) begin
        m[j] = vb[mi];
      end
    end
  end

  // uintvar groups, left aligned, continuation on all but the final one
  always_comb begin
    u  = '0;
    gi = '0;
    for (int j = 0; j < 5; j++) begin
      gi = g - 3'd1 - 3'(j);
      if (3'(j) < g) begin
        u[j] = {(gi != 3'd0), grp[gi]};
      end
    end
  end

  always_comb begin
    enc = '0;
    case (req.kind)
      wsp_enc_pkg::KIND_INT8: begin
        enc.bytes[0] = vb[0];
        enc.count    = 3'd1;
      end
      wsp_enc_pkg::KIND_INT16: begin
        enc.bytes[0] = vb[1];
        enc.bytes[1] = vb[0];
        enc.count    = 3'd2;
      end
      wsp_enc_pkg::KIND_INT32: begin
        for (int j = 0; j < 4; j++) begin
          enc.bytes[j] = vb[3-j];
        end
        enc.count = 3'd4;
      end
      wsp_enc_pkg::KIND_SHORT: begin
        enc.bytes[0] = vb[0] | wsp_enc_pkg::SHORT_FLAG;
        enc.count    = 3'd1;
      end
      wsp_enc_pkg::KIND_LONG, wsp_enc_pkg::KIND_INTEGER: begin
        if (req.kind == wsp_enc_pkg::KIND_INTEGER &&
            v <= {24'h0, wsp_enc_pkg::SHORT_MAX}) begin
          enc.bytes[0] = vb[0] | wsp_enc_pkg::SHORT_FLAG;
          enc.count    = 3'd1;
        end else if (v == 32'h0) begin
          enc.bytes[0] = 8'h01;
          enc.bytes[1] = 8'h00;
          enc.count    = 3'd2;
        end else begin
          enc.bytes[0] = {5'b00000, mb};
          for (int j = 0; j < 4; j++) begin
            enc.bytes[j+1] = m[j];
          end
          enc.count = mb + 3'd1;
        end
      end
      wsp_enc_pkg::KIND_UINTVAR: begin
        for (int j = 0; j < 5; j++) begin
          enc.bytes[j] = u[j];
        end
        enc.count = g;
      end
      wsp_enc_pkg::KIND_VLENGTH: begin
        if (v <= {24'h0, wsp_enc_pkg::VLEN_MAX}) begin
          enc.bytes[0] = vb[0];
          enc.count    = 3'd1;
        end else begin
          enc.bytes[0] = wsp_enc_pkg::VLEN_QUOTE;
          for (int j = 0; j < 5; j++) begin
            enc.bytes[j+1] = u[j];
          end
          enc.count = g + 3'd1;
        end
      end
      wsp_enc_pkg::KIND_MINIMAL: begin
        for (int j = 0; j < 4; j++) begin
          enc.bytes[j] = m[j];
        end
        enc.count = mb;
      end
      default: begin
        enc = '0;
      end
    endcase
  end

endmodule

### rtl/core/wsp_enc_serial.sv
// result register: holds the encoded bytes and sends one per cycle while dst_ready is high
// depends on wsp_enc_pkg
module wsp_enc_serial (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  held_valid,
  input  wsp_enc_pkg::enc_t     enc,
  output logic                  take,
  output logic                  dst_valid,
  input  logic                  dst_ready,
  output wsp_enc_pkg::out_req_t dst_data
);

  logic [wsp_enc_pkg::MaxBytes-1:0][7:0] bytes;
  logic [wsp_enc_pkg::MaxBytes-1:0][7:0] bytes_next;
  logic [2:0]                            cnt;
  logic [2:0]                            cnt_next;
  logic                                  can_load;

  assign dst_valid         = cnt != 3'd0;
  assign dst_data.out_byte = bytes[0];
  assign dst_data.last     = cnt == 3'd1;
  assign can_load          = (cnt == 3'd0) || (cnt == 3'd1 && dst_ready);
  assign take              = held_valid && can_load;

  always_comb begin
    bytes_next = bytes;
    cnt_next   = cnt;
    if (take) begin
      bytes_next = enc.bytes;
      cnt_next   = enc.count;
    end else if (dst_valid && dst_ready) begin
      bytes_next = {8'h00, bytes[wsp_enc_pkg::MaxBytes-1:1]};
      cnt_next   = cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    bytes <= bytes_next;
  end

endmodule

### rtl/core/wsp_integer_field_encoder_unit.sv
// wsp integer field encoder, top level
// a request is registered in the input stage, then encoded into the result register
// throughput: one byte per cycle while dst_ready is high, so a request's one to six bytes
//   (its encoded length) shift out of the six-byte result register, entry 0 first
// unused kinds give no bytes and show nothing at the output
// reset: synchronous, clears the stage and result valid state only
module wsp_integer_field_encoder_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  src_valid,
  output logic                  src_ready,
  input  wsp_enc_pkg::in_req_t  src_data,
  output logic                  dst_valid,
  input  logic                  dst_ready,
  output wsp_enc_pkg::out_req_t dst_data
);

  logic                 take;
  logic                 held_valid;
  wsp_enc_pkg::in_req_t held_data;
  wsp_enc_pkg::enc_t    enc;

  wsp_enc_stage u_stage (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_ready  (src_ready),
    .src_data   (src_data),
    .take       (take),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  wsp_enc_pack u_pack (
    .req (held_data),
    .enc (enc)
  );

  wsp_enc_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .enc        (enc),
    .take       (take),
    .dst_valid  (dst_valid),
    .dst_ready  (dst_ready),
    .dst_data   (dst_data)
  );

endmodule

### rtl/core/wsp_enc_checker.sv
// port checker for the wsp integer field encoder, bound to the top level
// depends on wsp_enc_pkg and wsp_integer_field_encoder_unit_assert.svh
`include "wsp_integer_field_encoder_unit_assert.svh"

module wsp_enc_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  src_ready,
  input logic                  dst_valid,
  input logic                  dst_ready,
  input wsp_enc_pkg::out_req_t dst_data
);

  // stalled byte holds
  `WSP_ASSERT_NEXT(a_dst_hold, dst_valid && !dst_ready,
    dst_valid && $stable(dst_data), "dst byte changed while stalled")

  // an encoding carries on until its last byte
  `WSP_ASSERT_NEXT(a_dst_cont, dst_valid && dst_ready && !dst_data.last,
    dst_valid, "encoding cut short")

  // with nothing waiting at the output, a request is always taken
  `WSP_ASSERT_NOW(a_src_free, !dst_valid, src_ready, "src stalled with empty output")

  // nothing shown straight after reset
  `WSP_ASSERT_NOW(a_rst_empty, $past(rst), !dst_valid, "dst valid after reset")

endmodule

bind wsp_integer_field_encoder_unit wsp_enc_checker u_chk (.*);
